/* hw/rtl/cphc_pkg.sv */
// Shared types and constants for the convex polygon half-plane clipper.
`timescale 1ns / 1ps

package cphc_pkg;

    // Width of the stored signed distance value of a vertex; covers every
    // fraction width down to eight bits.
    localparam int A_W = 58;

    // One vertex as it sits in a ring cell, with its distance to the cut line.
    typedef struct packed {
        logic signed [31:0]    x;
        logic signed [31:0]    y;
        logic signed [A_W-1:0] a;
    } t_vtx;

endpackage

/* hw/rtl/cphc_cell.sv */
// One ring cell: holds a vertex and takes its neighbor's or a written vertex.
`timescale 1ns / 1ps

module cphc_cell
    import cphc_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  logic i_sel,
    input  t_vtx i_nbr,
    input  t_vtx i_wd,
    output t_vtx o_q
);

    t_vtx r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_sel ? i_wd : i_nbr;
        end
    end

    assign o_q = r_q;

endmodule

/* hw/rtl/cphc_div.sv */
// Restoring divider that forms the interpolation fraction one bit a cycle.
`timescale 1ns / 1ps

module cphc_div #(
    parameter int FRAC_BITS = 16,
    parameter int DW        = 59
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_num,
    input  logic [DW-1:0]       i_den,
    output logic                o_done,
    output logic [FRAC_BITS:0]  o_t
);

    localparam int SW = $clog2(FRAC_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [DW:0]         r_rem;
    logic [DW-1:0]       r_den;
    logic [FRAC_BITS:0]  r_t;
    logic [SW-1:0]       r_cnt;
    logic [DW:0]         w_rem2;
    logic                w_ge;

    assign w_rem2 = {r_rem[DW-1:0], 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_rem <= {1'b0, i_num};
                r_cnt <= '0;
                if (i_num >= i_den) begin
                    r_t    <= (FRAC_BITS + 1)'(1) << FRAC_BITS;
                    r_done <= 1'b1;
                end else begin
                    r_t    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
                r_t   <= {r_t[FRAC_BITS-1:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_t    = r_t;

endmodule

/* hw/rtl/convex_polygon_halfplane_clip.sv */
// Top level of the convex polygon half-plane clipper with its ring of vertex cells.
`timescale 1ns / 1ps
// A cut runs from acceptance through the distance pass, a decision, the crossing scan,
// a check, two divider runs each followed by interpolation, and the rebuild pass;
// on the final item of a run an emission pass follows.
// Throughput: one item at a time, set by the ring walk through the shared head unit.
// Reset (synchronous, active low) empties the region, clears overflow and sets
// bound_scale to 1.0; vertex cells are not cleared.

module convex_polygon_halfplane_clip
    import cphc_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [30:0]  i_cfg_wdata,    // bound_scale
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,      // point_x, point_y, normal_x, normal_y
    input  logic         i_s_tuser,      // start_req
    input  logic         i_s_tlast,      // last
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,      // vertex_x, vertex_y, vertex_index, zero pad
    output logic [1:0]   o_m_tuser,      // empty_res, overflow
    output logic         o_m_tlast       // last_vertex
);

    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int QW  = CW + 1;
    localparam int DW  = A_W + 1;
    localparam int PRW = FRAC_BITS + 35;

    // The controller walks the ring through states with one hot bit each.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ACALC  = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_BUILD  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [CW-1:0]        r_cnt;
    logic                 r_ovf;
    logic [30:0]          r_bound;
    logic signed [31:0]   r_px, r_py, r_nx, r_ny;
    logic                 r_last;
    logic [CW-1:0]        r_i;
    logic [1:0]           r_ph;
    logic [CW-1:0]        r_nin;
    logic signed [32:0]   r_dx, r_dy;
    logic signed [64:0]   r_mx, r_my;
    t_vtx                 r_prev;
    logic                 r_pins;
    logic                 r_fm, r_fp;
    t_vtx                 r_va, r_vb, r_vc, r_vd;
    logic [CW-1:0]        r_m0, r_p1;
    logic                 r_which;
    t_vtx                 r_w0, r_w1;
    logic signed [PRW-1:0] r_pm_x, r_pm_y;
    logic [CW-1:0]        r_rem, r_k;

    logic                 r_ov;
    logic signed [31:0]   r_ox, r_oy;
    logic [5:0]           r_oidx;
    logic                 r_oempty, r_oovf, r_olast;

    // Ring of cells. Cell 0 is the head; a step moves every cell one place
    // toward the head and writes the vertices a step emits behind the
    // vertices not yet walked.
    t_vtx                 w_q   [MAX_VERTICES];
    t_vtx                 w_nbr [MAX_VERTICES];
    t_vtx                 w_wd  [MAX_VERTICES];
    logic                 w_en  [MAX_VERTICES];
    logic                 w_sel [MAX_VERTICES];

    t_vtx                 w_head;
    logic                 w_hins;
    logic                 w_acc;
    logic                 w_load;
    logic                 w_step, w_wr0, w_wr1;
    t_vtx                 w_d0, w_d1;
    logic [QW-1:0]        w_q0, w_q1;
    logic                 w_last_i;
    logic                 w_out_free;
    logic                 w_single;
    logic [CW-1:0]        w_m0_idx;
    logic [CW-1:0]        w_emit_n;

    logic signed [64:0]   w_shx, w_shy;
    logic signed [A_W-1:0] w_anew;
    logic signed [31:0]   w_sq;

    logic                 w_div_start, w_div_done;
    logic [FRAC_BITS:0]   w_t;
    logic signed [DW-1:0] w_num, w_den;
    t_vtx                 w_ea, w_eb;
    logic signed [PRW-1:0] w_sx, w_sy;

    assign w_head     = w_q[0];
    assign w_hins     = w_head.a <= 0;
    assign w_acc      = i_s_tvalid && (r_state == S_IDLE);
    assign w_load     = w_acc && i_s_tuser;
    assign w_last_i   = (r_i == CW'(r_cnt - 1'b1));
    assign w_out_free = !r_ov || i_m_tready;
    assign w_single   = (r_m0 == r_p1);
    assign w_m0_idx   = (r_i == '0) ? CW'(r_cnt - 1'b1) : CW'(r_i - 1'b1);
    assign w_sq       = $signed({1'b0, r_bound});

    // Distance value of the head vertex from the two registered products.
    assign w_shx  = r_mx >>> FRAC_BITS;
    assign w_shy  = r_my >>> FRAC_BITS;
    assign w_anew = w_shx[A_W-1:0] + w_shy[A_W-1:0];

    // Operands of the two crossing edges: entering edge first, then leaving edge.
    always_comb begin
        if (r_which) begin
            w_ea  = r_vc;
            w_eb  = r_vd;
            w_num = -$signed({r_vc.a[A_W-1], r_vc.a});
            w_den = $signed({r_vd.a[A_W-1], r_vd.a}) - $signed({r_vc.a[A_W-1], r_vc.a});
        end else begin
            w_ea  = r_va;
            w_eb  = r_vb;
            w_num = $signed({r_va.a[A_W-1], r_va.a});
            w_den = $signed({r_va.a[A_W-1], r_va.a}) - $signed({r_vb.a[A_W-1], r_vb.a});
        end
    end

    assign w_div_start = (r_state == S_DIV) && (r_ph == 2'd0);
    assign w_sx = r_pm_x >>> FRAC_BITS;
    assign w_sy = r_pm_y >>> FRAC_BITS;

    cphc_div #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_t     (w_t)
    );

    // Number of vertices the current rebuild step writes back.
    always_comb begin
        w_emit_n = '0;
        if (w_single) begin
            w_emit_n = (r_i == r_m0) ? CW'(2) : CW'(1);
        end else if ((r_i == r_m0) || (r_i == r_p1) || w_hins) begin
            w_emit_n = CW'(1);
        end
    end

    // Ring step control: which states walk the ring and what they write back.
    always_comb begin
        w_step = 1'b0;
        w_wr0  = 1'b0;
        w_wr1  = 1'b0;
        w_d0   = w_head;
        w_d1   = w_head;
        w_q0   = QW'(r_cnt) - 1'b1;
        case (r_state)
            S_ACALC: begin
                if ((r_cnt != '0) && (r_ph == 2'd2)) begin
                    w_step = 1'b1;
                    w_wr0  = 1'b1;
                    w_d0.a = w_anew;
                end
            end
            S_SCAN: begin
                w_step = 1'b1;
                w_wr0  = 1'b1;
            end
            S_BUILD: begin
                w_step = 1'b1;
                w_q0   = QW'(r_rem) - 1'b1 + QW'(r_k);
                if (w_single) begin
                    w_wr0 = 1'b1;
                    if (r_i == r_m0) begin
                        w_wr1 = 1'b1;
                        w_d0  = r_w1;
                        w_d1  = r_w0;
                    end
                end else if (r_i == r_m0) begin
                    w_wr0 = 1'b1;
                    w_d0  = r_w0;
                end else if (r_i == r_p1) begin
                    w_wr0 = 1'b1;
                    w_d0  = r_w1;
                end else if (w_hins) begin
                    w_wr0 = 1'b1;
                end
            end
            S_EMIT: begin
                if ((r_cnt != '0) && w_out_free) begin
                    w_step = 1'b1;
                    w_wr0  = 1'b1;
                end
            end
            default: begin
                w_step = 1'b0;
            end
        endcase
        w_q1 = w_q0 + 1'b1;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_ring
            if (g < MAX_VERTICES - 1) begin : g_nb
                assign w_nbr[g] = w_q[g + 1];
            end else begin : g_end
                assign w_nbr[g] = '0;
            end

            always_comb begin
                w_en[g]  = w_step;
                w_sel[g] = (w_wr0 && (w_q0 == QW'(g))) || (w_wr1 && (w_q1 == QW'(g)));
                w_wd[g]  = (w_wr1 && (w_q1 == QW'(g))) ? w_d1 : w_d0;
                if (w_load && (g < 4)) begin
                    // Start square, counterclockwise from the lower left corner.
                    w_en[g]    = 1'b1;
                    w_sel[g]   = 1'b1;
                    w_wd[g].x  = ((g == 1) || (g == 2)) ? w_sq : -w_sq;
                    w_wd[g].y  = (g >= 2) ? w_sq : -w_sq;
                    w_wd[g].a  = '0;
                end
            end

            cphc_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en[g]),
                .i_sel (w_sel[g]),
                .i_nbr (w_nbr[g]),
                .i_wd  (w_wd[g]),
                .o_q   (w_q[g])
            );
        end
    endgenerate

    // Main controller. At the end of a cut the block either goes back to
    // idle or, on the final item, walks the ring once more for emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_bound <= 31'd65536;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_ph    <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_bound <= i_cfg_wdata;
            end
            if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_px   <= i_s_tdata[31:0];
                        r_py   <= i_s_tdata[63:32];
                        r_nx   <= i_s_tdata[95:64];
                        r_ny   <= i_s_tdata[127:96];
                        r_last <= i_s_tlast;
                        if (i_s_tuser) begin
                            r_cnt <= CW'(4);
                            r_ovf <= 1'b0;
                        end
                        r_i     <= '0;
                        r_ph    <= '0;
                        r_nin   <= '0;
                        r_state <= S_ACALC;
                    end
                end
                S_ACALC: begin
                    if (r_cnt == '0) begin
                        r_i     <= '0;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        case (r_ph)
                            2'd0: begin
                                r_dx <= $signed({w_head.x[31], w_head.x}) -
                                        $signed({r_px[31], r_px});
                                r_dy <= $signed({w_head.y[31], w_head.y}) -
                                        $signed({r_py[31], r_py});
                                r_ph <= 2'd1;
                            end
                            2'd1: begin
                                r_mx <= r_dx * r_nx;
                                r_my <= r_dy * r_ny;
                                r_ph <= 2'd2;
                            end
                            default: begin
                                r_ph <= 2'd0;
                                if (w_anew <= 0) begin
                                    r_nin <= r_nin + 1'b1;
                                end
                                if (w_last_i) begin
                                    r_prev  <= w_d0;
                                    r_state <= S_DECIDE;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_DECIDE: begin
                    r_i <= '0;
                    if (r_nin == r_cnt) begin
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else if (r_nin == '0) begin
                        r_cnt   <= '0;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_fm    <= 1'b0;
                        r_fp    <= 1'b0;
                        r_pins  <= r_prev.a <= 0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // The first entering and first leaving transitions pick the cut edges.
                    if (!r_fm && !r_pins && w_hins) begin
                        r_fm <= 1'b1;
                        r_va <= r_prev;
                        r_vb <= w_head;
                        r_m0 <= w_m0_idx;
                    end
                    if (!r_fp && r_pins && !w_hins) begin
                        r_fp <= 1'b1;
                        r_vc <= r_prev;
                        r_vd <= w_head;
                        r_p1 <= r_i;
                    end
                    r_prev <= w_head;
                    r_pins <= w_hins;
                    if (w_last_i) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_CHECK: begin
                    r_i <= '0;
                    if (w_single && (r_cnt >= CW'(MAX_VERTICES))) begin
                        r_ovf   <= 1'b1;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_which <= 1'b0;
                        r_ph    <= 2'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (w_div_done) begin
                        r_ph    <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_ph == 2'd0) begin
                        r_pm_x <= ($signed({w_eb.x[31], w_eb.x}) -
                                   $signed({w_ea.x[31], w_ea.x})) * $signed({1'b0, w_t});
                        r_pm_y <= ($signed({w_eb.y[31], w_eb.y}) -
                                   $signed({w_ea.y[31], w_ea.y})) * $signed({1'b0, w_t});
                        r_ph   <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (r_which) begin
                            r_w1.x  <= w_ea.x + w_sx[31:0];
                            r_w1.y  <= w_ea.y + w_sy[31:0];
                            r_w1.a  <= '0;
                            r_i     <= '0;
                            r_rem   <= r_cnt;
                            r_k     <= '0;
                            r_state <= S_BUILD;
                        end else begin
                            r_w0.x  <= w_ea.x + w_sx[31:0];
                            r_w0.y  <= w_ea.y + w_sy[31:0];
                            r_w0.a  <= '0;
                            r_which <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_BUILD: begin
                    r_rem <= r_rem - 1'b1;
                    r_k   <= r_k + w_emit_n;
                    if (w_last_i) begin
                        r_cnt   <= r_k + w_emit_n;
                        r_i     <= '0;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ov   <= 1'b1;
                        r_oovf <= r_ovf;
                        if (r_cnt == '0) begin
                            // An empty region reports as one result with zero coordinates.
                            r_ox     <= '0;
                            r_oy     <= '0;
                            r_oidx   <= '0;
                            r_oempty <= 1'b1;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_ox     <= w_head.x;
                            r_oy     <= w_head.y;
                            r_oidx   <= 6'(r_i);
                            r_oempty <= 1'b0;
                            r_olast  <= w_last_i;
                            if (w_last_i) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {2'b00, r_oidx, r_oy, r_ox};
    assign o_m_tuser  = {r_oovf, r_oempty};
    assign o_m_tlast  = r_olast;

endmodule

/* test/cphc_checker.sv */
// Checker for the polygon clipper: predicts emitted vertices and compares them.
`timescale 1ns / 1ps

module cphc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [71:0]  i_m_tdata,
    input  logic [1:0]   i_m_tuser,
    input  logic         i_m_tlast,
    output int           o_errors,
    output int           o_pending
);

    localparam int NV = 32;
    localparam int FB = 16;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [5:0]  idx;
        logic        empty;
        logic        ovf;
        logic        lastv;
    } vertex_t;

    longint      ring_x [NV];
    longint      ring_y [NV];
    int          ring_n;
    bit          ovf_flag;
    logic [30:0] half_side;
    vertex_t     vertex_q[$];

    assign o_pending = vertex_q.size();

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic longint cut_point(input longint va, input longint vb,
                                         input logic signed [127:0] num,
                                         input logic signed [127:0] den);
        logic signed [127:0] t;
        logic signed [127:0] d;
        if (num >= den) t = 128'sd1 <<< FB;
        else t = (num <<< FB) / den;
        d = 128'(vb - va);
        return va + longint'((d * t) >>> FB);
    endfunction

    task automatic clip(input longint px, input longint py,
                        input longint nx, input longint ny);
        logic signed [127:0] a_val [NV];
        logic signed [127:0] dx, dy;
        bit  ins [NV];
        int  n, nin, m0, m1, p0, p1, pr, k;
        longint w0x, w0y, w1x, w1y;
        n = ring_n; nin = 0; m1 = -1; p1 = -1;
        if (n == 0) return;
        for (int i = 0; i < n; i++) begin
            dx = 128'(ring_x[i] - px);
            dy = 128'(ring_y[i] - py);
            a_val[i] = ((dx * nx) >>> FB) + ((dy * ny) >>> FB);
            ins[i] = a_val[i] <= 0;
            if (ins[i]) nin++;
        end
        if (nin == n) return;
        if (nin == 0) begin
            ring_n = 0;
            return;
        end
        for (int i = 0; i < n; i++) begin
            pr = (i + n - 1) % n;
            if (m1 < 0 && !ins[pr] && ins[i]) m1 = i;
            if (p1 < 0 && ins[pr] && !ins[i]) p1 = i;
        end
        m0 = (m1 + n - 1) % n;
        p0 = (p1 + n - 1) % n;
        // A lone outside vertex needs one extra cell; a full ring skips the cut.
        if (m0 == p1 && n >= NV) begin
            ovf_flag = 1'b1;
            return;
        end
        w0x = cut_point(ring_x[m0], ring_x[m1], a_val[m0], a_val[m0] - a_val[m1]);
        w0y = cut_point(ring_y[m0], ring_y[m1], a_val[m0], a_val[m0] - a_val[m1]);
        w1x = cut_point(ring_x[p0], ring_x[p1], -a_val[p0], a_val[p1] - a_val[p0]);
        w1y = cut_point(ring_y[p0], ring_y[p1], -a_val[p0], a_val[p1] - a_val[p0]);
        if (m0 == p1) begin
            for (int i = n; i >= m0 + 2; i--) begin
                ring_x[i] = ring_x[i-1];
                ring_y[i] = ring_y[i-1];
            end
            ring_x[m0] = w1x; ring_y[m0] = w1y;
            ring_x[m0+1] = w0x; ring_y[m0+1] = w0y;
            ring_n = n + 1;
        end else begin
            ring_x[m0] = w0x; ring_y[m0] = w0y;
            ring_x[p1] = w1x; ring_y[p1] = w1y;
            ins[m0] = 1'b1;
            ins[p1] = 1'b1;
            k = 0;
            for (int i = 0; i < n; i++) begin
                if (ins[i]) begin
                    ring_x[k] = ring_x[i];
                    ring_y[k] = ring_y[i];
                    k++;
                end
            end
            ring_n = k;
        end
    endtask

    task automatic take_halfplane();
        vertex_t v;
        longint s;
        if (i_s_tuser) begin
            s = longint'(half_side);
            ring_x[0] = -s; ring_y[0] = -s;
            ring_x[1] = s;  ring_y[1] = -s;
            ring_x[2] = s;  ring_y[2] = s;
            ring_x[3] = -s; ring_y[3] = s;
            ring_n = 4;
            ovf_flag = 1'b0;
        end
        clip(longint'($signed(i_s_tdata[31:0])), longint'($signed(i_s_tdata[63:32])),
             longint'($signed(i_s_tdata[95:64])), longint'($signed(i_s_tdata[127:96])));
        if (!i_s_tlast) return;
        if (ring_n == 0) begin
            v = '0;
            v.empty = 1'b1;
            v.ovf = ovf_flag;
            v.lastv = 1'b1;
            vertex_q.push_back(v);
        end else begin
            for (int i = 0; i < ring_n; i++) begin
                v.x = ring_x[i][31:0];
                v.y = ring_y[i][31:0];
                v.idx = i[5:0];
                v.empty = 1'b0;
                v.ovf = ovf_flag;
                v.lastv = (i + 1 == ring_n);
                vertex_q.push_back(v);
            end
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        vertex_t want;
        if (!i_rst_n) begin
            ring_n = 0;
            ovf_flag = 1'b0;
            half_side = 31'd65536;
            vertex_q.delete();
        end else begin
            if (i_cfg_wen) half_side = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) take_halfplane();
            if (i_m_tvalid && i_m_tready) begin
                if (vertex_q.size() == 0) begin
                    report("vertex item with nothing expected");
                end else begin
                    want = vertex_q.pop_front();
                    if (i_m_tdata[31:0] !== want.x)
                        report($sformatf("vertex_x %h, want %h", i_m_tdata[31:0], want.x));
                    if (i_m_tdata[63:32] !== want.y)
                        report($sformatf("vertex_y %h, want %h", i_m_tdata[63:32], want.y));
                    if (i_m_tdata[69:64] !== want.idx)
                        report($sformatf("vertex_index %0d, want %0d",
                                         i_m_tdata[69:64], want.idx));
                    if (i_m_tuser[0] !== want.empty)
                        report($sformatf("empty_res %b, want %b", i_m_tuser[0], want.empty));
                    if (i_m_tuser[1] !== want.ovf)
                        report($sformatf("overflow %b, want %b", i_m_tuser[1], want.ovf));
                    if (i_m_tlast !== want.lastv)
                        report($sformatf("last_vertex %b, want %b", i_m_tlast, want.lastv));
                end
            end
        end
    end

endmodule

/* test/tb.sv */
// Testbench top for the polygon clipper: drives half-plane items and gives the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  SETTLE       = 400;   // more than one full cut plus emission
    localparam real PI           = 3.14159265358979;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [30:0]  i_cfg_wdata = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         i_s_tlast = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [71:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    int errors;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;
    logic [30:0] cur_side = 31'd65536;

    always #2 i_clk = ~i_clk;

    convex_polygon_halfplane_clip uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    cphc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    // The run is cut off here if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver switches between patterns of random length. Once, early on,
    // it holds off for a long stretch so the block fills up and stalls its input.
    initial begin
        int mode;
        int run_left;
        int hold_left;
        int rx_cycles;
        mode = 0; run_left = 0; hold_left = 0; rx_cycles = 0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (rx_cycles == 3000) hold_left = 6000;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode = $urandom_range(0, 3);
                    run_left = $urandom_range(20, 200);
                end
                run_left--;
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    2: i_m_tready <= (run_left % 4) != 0;
                    default: i_m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offers one half-plane item and returns once it has been accepted. Items
    // come in bursts; a gap lowers the valid only after an acceptance.
    task automatic send(input logic [31:0] px, input logic [31:0] py,
                        input logic [31:0] nx, input logic [31:0] ny,
                        input logic st, input logic lst);
        int gap;
        i_s_tdata  <= {ny, nx, py, px};
        i_s_tuser  <= st;
        i_s_tlast  <= lst;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // A cut tangent-ish to the circle inscribed in the start square; a run of
    // these grows the ring one vertex at a time until the store is full.
    task automatic send_circle_cut(input logic st, input logic lst);
        real ang, rad;
        int nx, ny, px, py;
        ang = $urandom_range(0, 35999) * 2.0 * PI / 36000.0;
        rad = cur_side * ($urandom_range(900, 999) / 1000.0);
        nx = $rtoi(4096.0 * $cos(ang));
        ny = $rtoi(4096.0 * $sin(ang));
        px = $rtoi(rad * $cos(ang));
        py = $rtoi(rad * $sin(ang));
        send(px, py, nx, ny, st, lst);
    endtask

    task automatic send_random_cut(input logic st, input logic lst);
        int kind;
        logic [31:0] px, py;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            send_circle_cut(st, lst);
        end else if (kind < 85) begin
            send($urandom, $urandom, $urandom, $urandom, st, lst);
        end else if (kind < 95) begin
            // Line through the square with a random normal of any magnitude.
            px = $urandom_range(0, 2 * cur_side) - cur_side;
            py = $urandom_range(0, 2 * cur_side) - cur_side;
            send(px, py, $urandom >> $urandom_range(0, 31),
                 $urandom >> $urandom_range(0, 31), st, lst);
        end else begin
            send($urandom, $urandom, 32'd0, 32'd0, st, lst);
        end
    endtask

    // Runs of cuts that start from the square and end with an emission; a few
    // runs continue the previous region or emit midway.
    task automatic random_phase(input int items);
        int done, len;
        bit cont;
        done = 0;
        while (done < items) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(35, 50) : $urandom_range(1, 12);
            cont = ($urandom_range(0, 11) == 0);
            for (int i = 0; i < len; i++)
                send_random_cut(i == 0 && !cont, i == len - 1 || $urandom_range(0, 19) == 0);
            done += len;
        end
    endtask

    // The block is idle once every vertex has come out and a last cut with no
    // emission has had time to finish.
    task automatic set_side(input logic [30:0] side);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wdata <= side;
        i_cfg_wen   <= 1'b1;
        cur_side = side;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Emission straight after reset gives the empty marker.
        send(32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
        set_side(31'd65536);
        // Zero normal keeps the square.
        send(32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
        // Cut through the middle.
        send(32'd0, 32'd0, 32'd65536, 32'd0, 1'b1, 1'b1);
        // Everything outside empties the region; cuts on an empty region do nothing.
        send(32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 1'b1, 1'b0);
        send(32'd0, 32'd0, 32'd65536, 32'd65536, 1'b0, 1'b1);
        // One corner cut off grows the ring by a vertex.
        send(32'd58982, 32'd58982, 32'd65536, 32'd65536, 1'b1, 1'b1);
        // Extremes of every field.
        send(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
        send(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1);
        send(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
        send(32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1);
        send(32'd0, 32'd0, 32'hffff_ffff, 32'd0, 1'b1, 1'b1);
        // A run of circle cuts from the start square, emitted after the last one.
        for (int i = 0; i < 12; i++) send_circle_cut(i == 0, i == 11);

        random_phase(80);
        set_side(31'd0);
        random_phase(30);
        set_side(31'h7fff_ffff);
        random_phase(70);
        set_side(31'($urandom_range(1, 1 << 24)));
        random_phase(70);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cphc_pkg.sv
hw/rtl/cphc_cell.sv
hw/rtl/cphc_div.sv
hw/rtl/convex_polygon_halfplane_clip.sv
test/cphc_checker.sv
test/tb.sv
